// File: rtl/core/skpq_pkg.sv
// Package for the sorted key priority queue core.
// Holds operation codes, fault codes, controller states and command/status structs.
package skpq_pkg;

  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_DEQ   = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_FULL  = 2'd2;

  // Most result words one range query returns
  localparam int RESULT_LIMIT = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_OUT,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic exec;      // apply enqueue or dequeue, build its result
    logic scan_init; // start range scan at entry 0
    logic scan_step; // advance scan pointer
    logic emit;      // put current match in output register
    logic emit_fail; // put empty-range fault in output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_range;
    logic is_nop;
    logic scan_end;   // pointer reached entry count
    logic scan_hit;   // current entry lies in range
    logic limit_hit;  // result limit reached
    logic any_hit;    // at least one match emitted
    logic next_hit;   // a later entry also matches (within limit)
  } status_t;

endpackage

// File: rtl/core/skpq_datapath.sv
// Datapath of the sorted key priority queue: sorted register table,
// parallel compare, shift insert/remove, range scan pointer and output register.
// Depends on skpq_pkg.
module skpq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  skpq_pkg::cmd_t      cmd,
  output skpq_pkg::status_t   status,
  input  logic [1:0]          mode,
  input  logic [31:0]         item_key,
  input  logic signed [31:0]  item_value,
  input  logic                item_has_value,
  input  logic [31:0]         range_end,
  input  logic                out_load,
  output logic                ok,
  output logic [31:0]         out_key,
  output logic signed [31:0]  out_value,
  output logic                out_has_value,
  output logic [1:0]          fault,
  output logic                last
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(skpq_pkg::RESULT_LIMIT + 1);

  logic [31:0] keys [CAPACITY];
  logic [31:0] vals [CAPACITY];
  logic        pres [CAPACITY];
  logic [CW-1:0] count;

  logic [1:0]  r_mode;
  logic [31:0] r_key, r_val, r_end;
  logic        r_has;

  logic [CW-1:0] ptr;
  logic [LW-1:0] nres;

  logic [CAPACITY-1:0] lt, eq, inr;
  logic [CW-1:0] pos;
  logic found;
  logic [IW-1:0] pos_i, ptr_i;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode;
      r_key  <= item_key;
      r_val  <= item_has_value ? item_value : 32'sd0;
      r_has  <= item_has_value;
      r_end  <= range_end;
    end
  end

  // Parallel compare against every live entry
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i]  = (CW'(i) < count) && (keys[i] < r_key);
      eq[i]  = (CW'(i) < count) && (keys[i] == r_key);
      inr[i] = (CW'(i) < count) && (keys[i] >= r_key) && (keys[i] <= r_end);
      pos = pos + CW'(lt[i]);
    end
  end
  assign found = |eq;
  assign pos_i = pos[IW-1:0];
  assign ptr_i = ptr[IW-1:0];

  // Any match strictly after ptr
  logic later;
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < CAPACITY; i++)
      if (CW'(i) > ptr) later = later | inr[i];
  end

  assign status.is_range  = (r_mode == skpq_pkg::MODE_RANGE);
  assign status.is_nop    = (r_mode != skpq_pkg::MODE_ENQ) && (r_mode != skpq_pkg::MODE_DEQ)
                            && (r_mode != skpq_pkg::MODE_RANGE);
  assign status.scan_end  = (ptr >= count);
  assign status.scan_hit  = (ptr < count) && inr[ptr_i];
  assign status.limit_hit = (nres >= LW'(skpq_pkg::RESULT_LIMIT));
  assign status.any_hit   = (nres != '0);
  assign status.next_hit  = later && ((nres + LW'(1)) < LW'(skpq_pkg::RESULT_LIMIT));

  logic is_full;
  assign is_full = (count >= CW'(CAPACITY));

  // Table update
  always_ff @(posedge clk) begin
    if (cmd.exec && r_mode == skpq_pkg::MODE_ENQ && (found || !is_full)) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (found) begin
          if (eq[i]) begin
            vals[i] <= r_val;
            pres[i] <= r_has;
          end
        end else if (CW'(i) == pos) begin
          keys[i] <= r_key;
          vals[i] <= r_val;
          pres[i] <= r_has;
        end else if (CW'(i) > pos && i > 0) begin
          keys[i] <= keys[i-1];
          vals[i] <= vals[i-1];
          pres[i] <= pres[i-1];
        end
      end
    end else if (cmd.exec && r_mode == skpq_pkg::MODE_DEQ && count != '0) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        keys[i] <= keys[i+1];
        vals[i] <= vals[i+1];
        pres[i] <= pres[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (r_mode == skpq_pkg::MODE_ENQ && !found && !is_full)
        count <= count + CW'(1);
      else if (r_mode == skpq_pkg::MODE_DEQ && count != '0)
        count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      ptr  <= '0;
      nres <= '0;
    end else begin
      if (cmd.scan_step) ptr <= ptr + CW'(1);
      if (cmd.emit) nres <= nres + LW'(1);
    end
  end

  // Output register, loaded only when the output side is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.exec) begin
        last <= 1'b1;
        if (r_mode == skpq_pkg::MODE_ENQ) begin
          if (found || !is_full) begin
            ok <= 1'b1; out_key <= r_key; out_value <= r_val;
            out_has_value <= r_has; fault <= skpq_pkg::FAULT_NONE;
          end else begin
            ok <= 1'b0; out_key <= r_key; out_value <= '0;
            out_has_value <= 1'b0; fault <= skpq_pkg::FAULT_FULL;
          end
        end else if (count != '0) begin
          ok <= 1'b1; out_key <= keys[0]; out_value <= vals[0];
          out_has_value <= pres[0]; fault <= skpq_pkg::FAULT_NONE;
        end else begin
          ok <= 1'b0; out_key <= '0; out_value <= '0;
          out_has_value <= 1'b0; fault <= skpq_pkg::FAULT_EMPTY;
        end
      end else if (cmd.emit) begin
        ok <= 1'b1; out_key <= keys[ptr_i]; out_value <= vals[ptr_i];
        out_has_value <= pres[ptr_i]; fault <= skpq_pkg::FAULT_NONE;
        last <= !status.next_hit;
      end else if (cmd.emit_fail) begin
        ok <= 1'b0; out_key <= '0; out_value <= '0;
        out_has_value <= 1'b0; fault <= skpq_pkg::FAULT_EMPTY; last <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/skpq_ctrl.sv
// Controller of the sorted key priority queue: sequences load, execute and range scan,
// and owns the output valid flag. Depends on skpq_pkg.
module skpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_load,
  output skpq_pkg::cmd_t     cmd,
  input  skpq_pkg::status_t  status
);
  skpq_pkg::state_t state, state_next;
  logic out_free, out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skpq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      skpq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = skpq_pkg::ST_EXEC;
        end
      end
      skpq_pkg::ST_EXEC: begin
        if (status.is_nop) begin
          state_next = skpq_pkg::ST_IDLE;
        end else if (status.is_range) begin
          cmd.scan_init = 1'b1;
          state_next = skpq_pkg::ST_SCAN;
        end else if (out_free) begin
          cmd.exec = 1'b1;
          out_valid_next = 1'b1;
          state_next = skpq_pkg::ST_IDLE;
        end
      end
      skpq_pkg::ST_SCAN: begin
        // one entry per cycle, held on a hit until the output is free; stop on end of table or result limit
        if (status.scan_end || status.limit_hit) begin
          if (status.any_hit) begin
            state_next = skpq_pkg::ST_IDLE;
          end else if (out_free) begin
            cmd.emit_fail = 1'b1;
            out_valid_next = 1'b1;
            state_next = skpq_pkg::ST_IDLE;
          end
        end else if (status.scan_hit) begin
          if (out_free) begin
            cmd.emit = 1'b1;
            cmd.scan_step = 1'b1;
            out_valid_next = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_next = skpq_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: rtl/core/sorted_key_priority_queue_core.sv
// Sorted key priority queue core: bounded sorted table with key update.
// Enqueue/dequeue: accept, then execute once the output register is free.
// Range query: accept, scan setup, then one table entry per cycle, held on a hit until the output is free,
// and a finishing step that emits the empty-range fault when nothing matched.
// One word in flight at a time; the output register lets a result wait while the next is taken.
// Synchronous active-high reset empties the table (count to zero) and clears output valid.
module sorted_key_priority_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [31:0]        item_key,
  input  logic signed [31:0] item_value,
  input  logic               item_has_value,
  input  logic [31:0]        range_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [31:0]        out_key,
  output logic signed [31:0] out_value,
  output logic               out_has_value,
  output logic [1:0]         fault,
  output logic               last
);
  skpq_pkg::cmd_t    cmd;
  skpq_pkg::status_t status;
  logic              out_load;

  // Sequencer: steps each word through load, execute or scan
  skpq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_load, .cmd, .status
  );

  // Table, comparators and output register
  skpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .status, .mode, .item_key, .item_value, .item_has_value,
    .range_end, .out_load, .ok, .out_key, .out_value, .out_has_value, .fault, .last
  );
endmodule

// File: tb/sv/tb_top.sv
// Testbench for sorted_key_priority_queue_core: random and directed words against a
// scoreboard class that keeps its own sorted table. Depends on skpq_pkg and the core RTL.
module tb_top;

  localparam int DEPTH     = 16;
  localparam int MAX_CYC   = 1000000;
  localparam int N_RANDOM  = 460;

  typedef struct packed {
    logic        ok;
    logic [31:0] key;
    logic [31:0] value;
    logic        has_value;
    logic [1:0]  fault;
    logic        last;
  } qres_t;

  // Scoreboard: shadow sorted table and queue of expected result words.
  class queue_scoreboard;
    logic [31:0] keys[DEPTH];
    logic [31:0] vals[DEPTH];
    logic        pres[DEPTH];
    int          count;
    qres_t       pending[$];
    int          errors;
    int          n_checked;

    function void post(logic ok, logic [31:0] k, logic [31:0] v, logic h,
                       logic [1:0] f, logic l);
      qres_t r;
      r.ok = ok; r.key = k; r.value = v; r.has_value = h; r.fault = f; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_word(logic [1:0] md, logic [31:0] k, logic [31:0] v,
                            logic h, logic [31:0] e);
      int pos;
      int n;
      logic [31:0] sv;
      pos = 0;
      n = 0;
      sv = h ? v : 32'd0;
      if (md == skpq_pkg::MODE_ENQ) begin
        while (pos < count && keys[pos] < k) pos++;
        if (pos < count && keys[pos] == k) begin
          vals[pos] = sv; pres[pos] = h;
          post(1'b1, k, sv, h, skpq_pkg::FAULT_NONE, 1'b1);
        end else if (count >= DEPTH) begin
          post(1'b0, k, 32'd0, 1'b0, skpq_pkg::FAULT_FULL, 1'b1);
        end else begin
          for (int i = count; i > pos; i--) begin
            keys[i] = keys[i-1]; vals[i] = vals[i-1]; pres[i] = pres[i-1];
          end
          keys[pos] = k; vals[pos] = sv; pres[pos] = h;
          count++;
          post(1'b1, k, sv, h, skpq_pkg::FAULT_NONE, 1'b1);
        end
      end else if (md == skpq_pkg::MODE_DEQ) begin
        if (count == 0) begin
          post(1'b0, 32'd0, 32'd0, 1'b0, skpq_pkg::FAULT_EMPTY, 1'b1);
        end else begin
          post(1'b1, keys[0], vals[0], pres[0], skpq_pkg::FAULT_NONE, 1'b1);
          for (int i = 1; i < count; i++) begin
            keys[i-1] = keys[i]; vals[i-1] = vals[i]; pres[i-1] = pres[i];
          end
          count--;
        end
      end else if (md == skpq_pkg::MODE_RANGE) begin
        for (int i = 0; i < count && n < skpq_pkg::RESULT_LIMIT; i++) begin
          if (keys[i] >= k && keys[i] <= e) begin
            post(1'b1, keys[i], vals[i], pres[i], skpq_pkg::FAULT_NONE, 1'b0);
            n++;
          end
        end
        if (n == 0) post(1'b0, 32'd0, 32'd0, 1'b0, skpq_pkg::FAULT_EMPTY, 1'b1);
        else pending[$].last = 1'b1;
      end
    endfunction

    function void check_word(qres_t got);
      qres_t want;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = skpq_pkg::MODE_ENQ;
  logic [31:0]        item_key = '0;
  logic signed [31:0] item_value = '0;
  logic               item_has_value = 1'b0;
  logic [31:0]        range_end = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic               ok;
  logic [31:0]        out_key;
  logic signed [31:0] out_value;
  logic               out_has_value;
  logic [1:0]         fault;
  logic               last;

  queue_scoreboard sb;
  int  cycles = 0;
  int  n_words = 0;
  int  n_ranges = 0;
  bit  hold_off = 1'b0;
  logic [31:0] key_pool[8];

  always #10 clk = ~clk;

  sorted_key_priority_queue_core #(.CAPACITY(DEPTH)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .item_key(item_key), .item_value(item_value), .item_has_value(item_has_value),
    .range_end(range_end), .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .out_key(out_key), .out_value(out_value), .out_has_value(out_has_value),
    .fault(fault), .last(last)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Note every word the block takes, in order, before anything else moves.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_word(mode, item_key, item_value, item_has_value, range_end);
      n_words++;
      if (mode == skpq_pkg::MODE_RANGE) n_ranges++;
    end
  end

  // Check every result word the block hands over.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word({ok, out_key, out_value, out_has_value, fault, last});
  end

  // Receiver: random stalls per word; hold off completely during the pressure phase.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_off || ($urandom_range(0, 3) == 0)) begin
        out_stall <= 1'b1;
        gap = hold_off ? 0 : $urandom_range(0, 13);
        repeat (gap) @(posedge clk);
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(logic [1:0] md, logic [31:0] k, logic [31:0] v,
                           logic h, logic [31:0] e, bit idle_ok);
    int gap;
    gap = idle_ok ? $urandom_range(0, 13) : 0;
    if (idle_ok && $urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md; item_key <= k; item_value <= v; item_has_value <= h; range_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return key_pool[$urandom_range(0, 7)];
      default: return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
    endcase
  endfunction

  initial begin
    logic [1:0]  md;
    logic [31:0] a;
    logic [31:0] b;
    sb = new();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, extremes, key update, absent value, full table, ranges.
    send_word(skpq_pkg::MODE_DEQ, 32'd0, 32'd0, 1'b0, 32'd0, 0);
    send_word(skpq_pkg::MODE_RANGE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 0);
    send_word(skpq_pkg::MODE_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd0, 0);
    send_word(skpq_pkg::MODE_ENQ, 32'd0, 32'h8000_0000, 1'b1, 32'd0, 0);
    send_word(skpq_pkg::MODE_ENQ, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 0);
    send_word(skpq_pkg::MODE_NOP, 32'h1234, 32'd5, 1'b1, 32'h5678, 0);
    send_word(skpq_pkg::MODE_RANGE, 32'd10, 32'hFFFF_FFFF, 1'b0, 32'd5, 0);
    for (int i = 0; i < 16; i++)
      send_word(skpq_pkg::MODE_ENQ, 32'h100 * (16 - i), $urandom(), i[0], 32'd0, 0);
    send_word(skpq_pkg::MODE_ENQ, 32'h55, 32'd1, 1'b1, 32'd0, 0);
    send_word(skpq_pkg::MODE_RANGE, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0);
    send_word(skpq_pkg::MODE_DEQ, 32'd0, 32'd0, 1'b0, 32'd0, 0);

    // Pressure: receiver holds off while the sender keeps offering.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++)
          send_word(skpq_pkg::MODE_ENQ, $urandom(), $urandom(), 1'b1, 32'd0, 0);
      end
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join

    // Random mix: enqueue-heavy and dequeue-heavy stretches so the table fills and drains.
    for (int i = 0; i < N_RANDOM; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (((i / 60) % 2) == 0)
        md = (r < 55) ? skpq_pkg::MODE_ENQ : (r < 75) ? skpq_pkg::MODE_DEQ
                                                      : skpq_pkg::MODE_RANGE;
      else
        md = (r < 25) ? skpq_pkg::MODE_ENQ : (r < 70) ? skpq_pkg::MODE_DEQ
                                                      : skpq_pkg::MODE_RANGE;
      if (r == 99) md = skpq_pkg::MODE_NOP;
      a = pick_key();
      b = ($urandom_range(0, 5) == 0) ? pick_key() : a + ($urandom() >> $urandom_range(0, 31));
      if (b < a && $urandom_range(0, 3) != 0) b = 32'hFFFF_FFFF;
      send_word(md, a, $urandom(), $urandom_range(0, 1), b, i % 50 > 8);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH * 4 + 40) @(posedge clk);
    $display("Covered %0d words (%0d range queries), %0d result words checked.",
             n_words, n_ranges, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
